/* rtl/core/crt_pkg.sv */
package crt_pkg;

    // Default sizing of the symbol table and address datapath
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int ADDR_WIDTH_DEF    = 32;

    // Fixed field widths of the item and result ports
    localparam int FIELD_W = 32;
    localparam int DEPTH_W = 16;
    localparam int INDEX_W = 8;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // Item kinds on the command port
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_RETIRE = 2'd2
    } kind_t;

    // RISC-V encodings used by the jump classifier
    localparam logic [6:0] OPC_JAL  = 7'h6f;
    localparam logic [6:0] OPC_JALR = 7'h67;
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_T0   = 5'd5;

    // Classification of one retired instruction
    typedef struct packed {
        logic is_call;
        logic is_ret;
    } jump_t;

    // Outcome of one table scan for the target and the current pc
    typedef struct packed {
        logic               t_found;
        logic [INDEX_W-1:0] t_index;
        logic               c_found;
        logic [INDEX_W-1:0] c_index;
    } lookup_t;

endpackage

/* rtl/core/crt_ram.sv */
module crt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/crt_decode.sv */
module crt_decode (
    input  logic [crt_pkg::FIELD_W-1:0] instruction,
    output crt_pkg::jump_t              jump
);

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [11:0] imm;
    logic        link;

    assign opcode = instruction[6:0];
    assign rd     = instruction[11:7];
    assign rs1    = instruction[19:15];
    assign imm    = instruction[31:20];

    // Link into ra or t0 marks a call; jalr back through ra or t0 marks a return
    assign link = (rd == crt_pkg::REG_RA) || (rd == crt_pkg::REG_T0);

    assign jump.is_call = ((opcode == crt_pkg::OPC_JAL) || (opcode == crt_pkg::OPC_JALR)) && link;
    assign jump.is_ret  = (opcode == crt_pkg::OPC_JALR) && (rd == crt_pkg::REG_ZERO)
                          && ((rs1 == crt_pkg::REG_RA) || (rs1 == crt_pkg::REG_T0))
                          && (imm == '0);

endmodule

/* rtl/core/crt_scan.sv */
module crt_scan #(
    parameter int TABLE_ENTRIES = crt_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_WIDTH    = crt_pkg::ADDR_WIDTH_DEF,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES),
    localparam int CNT_W        = $clog2(TABLE_ENTRIES + 1),
    localparam int ENTRY_W      = ADDR_WIDTH + crt_pkg::FIELD_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [ADDR_WIDTH-1:0] target_addr,
    input  logic [ADDR_WIDTH-1:0] current_addr,
    input  logic [CNT_W-1:0]      entry_count,
    output logic [IDX_W-1:0]      rd_addr,
    input  logic [ENTRY_W-1:0]    rd_data,
    output logic                  busy,
    output logic                  done,
    output crt_pkg::lookup_t      lookup
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                  state_reg,     state_next;
    logic [CNT_W-1:0]        issue_reg,     issue_next;
    logic                    rvalid_reg,    rvalid_next;
    logic [IDX_W-1:0]        ridx_reg,      ridx_next;
    logic                    have_prev_reg, have_prev_next;
    logic [ADDR_WIDTH-1:0]   prev_start_reg, prev_start_next;
    logic [crt_pkg::FIELD_W-1:0] prev_size_reg, prev_size_next;
    logic [IDX_W-1:0]        prev_idx_reg,  prev_idx_next;
    logic [ADDR_WIDTH-1:0]   t_addr_reg,    t_addr_next;
    logic [ADDR_WIDTH-1:0]   c_addr_reg,    c_addr_next;
    logic                    t_found_reg,   t_found_next;
    logic [IDX_W-1:0]        t_idx_reg,     t_idx_next;
    logic                    c_found_reg,   c_found_next;
    logic [IDX_W-1:0]        c_idx_reg,     c_idx_next;
    logic                    done_reg,      done_next;

    logic [ADDR_WIDTH-1:0]       data_start;
    logic [crt_pkg::FIELD_W-1:0] data_size;
    logic                        issue_more;
    logic                        finish;
    logic                        eval_now;
    logic                        t_hit;
    logic                        c_hit;
    logic [IDX_W+7:0]            t_idx_wide;
    logic [IDX_W+7:0]            c_idx_wide;

    // Range test of one entry; a zero size reaches up to the next start
    function automatic logic entry_holds(
        input logic [ADDR_WIDTH-1:0]       addr,
        input logic [ADDR_WIDTH-1:0]       start,
        input logic [crt_pkg::FIELD_W-1:0] size,
        input logic [ADDR_WIDTH-1:0]       nxt,
        input logic                        has_next
    );
        logic [ADDR_WIDTH-1:0] offset;
        logic                  in_range;
        offset = addr - start;
        if (size != '0)
        begin
            in_range = offset < ADDR_WIDTH'(size);
        end
        else if (has_next)
        begin
            in_range = addr < nxt;
        end
        else
        begin
            in_range = addr == start;
        end
        return (addr >= start) && in_range;
    endfunction

    assign data_start = rd_data[ADDR_WIDTH-1:0];
    assign data_size  = rd_data[ENTRY_W-1:ADDR_WIDTH];

    // One read issued per cycle; entry i is judged once entry i+1 is back
    assign issue_more = issue_reg < entry_count;
    assign finish     = (state_reg == S_SCAN) && !issue_more && !rvalid_reg;
    assign eval_now   = (state_reg == S_SCAN) && have_prev_reg && (rvalid_reg || finish);

    assign t_hit = eval_now
                   && entry_holds(t_addr_reg, prev_start_reg, prev_size_reg, data_start, rvalid_reg);
    assign c_hit = eval_now
                   && entry_holds(c_addr_reg, prev_start_reg, prev_size_reg, data_start, rvalid_reg);

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        rvalid_next     = rvalid_reg;
        ridx_next       = ridx_reg;
        have_prev_next  = have_prev_reg;
        prev_start_next = prev_start_reg;
        prev_size_next  = prev_size_reg;
        prev_idx_next   = prev_idx_reg;
        t_addr_next     = t_addr_reg;
        c_addr_next     = c_addr_reg;
        t_found_next    = t_found_reg;
        t_idx_next      = t_idx_reg;
        c_found_next    = c_found_reg;
        c_idx_next      = c_idx_reg;
        done_next       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch both addresses and restart the sweep
                if (go)
                begin
                    state_next     = S_SCAN;
                    issue_next     = '0;
                    rvalid_next    = 1'b0;
                    have_prev_next = 1'b0;
                    t_addr_next    = target_addr;
                    c_addr_next    = current_addr;
                    t_found_next   = 1'b0;
                    t_idx_next     = '0;
                    c_found_next   = 1'b0;
                    c_idx_next     = '0;
                end
            end
            S_SCAN:
            begin
                // Advance the read pointer
                rvalid_next = issue_more;
                ridx_next   = issue_reg[IDX_W-1:0];
                if (issue_more)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                // Shift returned entry into the compare slot
                if (rvalid_reg)
                begin
                    have_prev_next  = 1'b1;
                    prev_start_next = data_start;
                    prev_size_next  = data_size;
                    prev_idx_next   = ridx_reg;
                end
                // Keep the first hit only
                if (t_hit && !t_found_reg)
                begin
                    t_found_next = 1'b1;
                    t_idx_next   = prev_idx_reg;
                end
                if (c_hit && !c_found_reg)
                begin
                    c_found_next = 1'b1;
                    c_idx_next   = prev_idx_reg;
                end
                if (finish)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_reg      <= '0;
            rvalid_reg     <= 1'b0;
            ridx_reg       <= '0;
            have_prev_reg  <= 1'b0;
            prev_start_reg <= '0;
            prev_size_reg  <= '0;
            prev_idx_reg   <= '0;
            t_addr_reg     <= '0;
            c_addr_reg     <= '0;
            t_found_reg    <= 1'b0;
            t_idx_reg      <= '0;
            c_found_reg    <= 1'b0;
            c_idx_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            rvalid_reg     <= rvalid_next;
            ridx_reg       <= ridx_next;
            have_prev_reg  <= have_prev_next;
            prev_start_reg <= prev_start_next;
            prev_size_reg  <= prev_size_next;
            prev_idx_reg   <= prev_idx_next;
            t_addr_reg     <= t_addr_next;
            c_addr_reg     <= c_addr_next;
            t_found_reg    <= t_found_next;
            t_idx_reg      <= t_idx_next;
            c_found_reg    <= c_found_next;
            c_idx_reg      <= c_idx_next;
            done_reg       <= done_next;
        end
    end

    // Report the low byte of each entry number
    assign t_idx_wide = (IDX_W + 8)'(t_idx_reg);
    assign c_idx_wide = (IDX_W + 8)'(c_idx_reg);

    assign rd_addr        = issue_reg[IDX_W-1:0];
    assign busy           = state_reg == S_SCAN;
    assign done           = done_reg;
    assign lookup.t_found = t_found_reg;
    assign lookup.t_index = t_idx_wide[7:0];
    assign lookup.c_found = c_found_reg;
    assign lookup.c_index = c_idx_wide[7:0];

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("scan result strobed while still scanning");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg <= entry_count))
        else $error("scan read pointer ran past the table fill");

    a_rvalid_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (state_reg == S_SCAN) && $past(state_reg == S_SCAN))
        else $error("read data returned outside a scan");

    a_found_index: assert property (@(posedge clk) disable iff (!rst_n)
        (t_found_reg && (state_reg == S_SCAN)) |-> (CNT_W'(t_idx_reg) < entry_count))
        else $error("target hit on an entry beyond the fill");
`endif

endmodule

/* rtl/core/call_return_trace_with_symbol_lookup_unit.sv */
// Call/return trace unit. Items are offered on start and taken at an edge where busy is low.
// Clear, append and non-jump instructions leave busy low. A call or return (with trace_enable
// set) scans the symbol table through the single read port of the table RAM, one entry per
// cycle, with busy high for the scan; the result appears on the cycle right after busy falls,
// marked by result_valid for exactly one cycle. The receiver cannot stall; it must take each
// result in that cycle. The table needs no clearing pass after reset since the fill count
// bounds every read. trace_enable is written through trace_enable_we; the user must do so
// only while the unit is idle, as the block itself does not enforce it.
module call_return_trace_with_symbol_lookup_unit #(
    parameter int TABLE_ENTRIES = crt_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_WIDTH    = crt_pkg::ADDR_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          trace_enable_we,
    input  logic                          trace_enable_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    kind,
    input  logic [crt_pkg::FIELD_W-1:0]   pc,
    input  logic [crt_pkg::FIELD_W-1:0]   instruction,
    input  logic [crt_pkg::FIELD_W-1:0]   next_address,
    input  logic [crt_pkg::FIELD_W-1:0]   symbol_start,
    input  logic [crt_pkg::FIELD_W-1:0]   symbol_size,
    output logic                          result_valid,
    output logic                          is_return,
    output logic [crt_pkg::FIELD_W-1:0]   event_pc,
    output logic [crt_pkg::FIELD_W-1:0]   target_address,
    output logic [crt_pkg::DEPTH_W-1:0]   indent_depth,
    output logic                          target_found,
    output logic [crt_pkg::INDEX_W-1:0]   target_index,
    output logic                          current_found,
    output logic [crt_pkg::INDEX_W-1:0]   current_index
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = ADDR_WIDTH + crt_pkg::FIELD_W;

    logic                          trace_enable_reg;
    logic [CNT_W-1:0]              entry_count_reg, entry_count_next;
    logic [crt_pkg::DEPTH_W-1:0]   depth_reg,       depth_next;
    logic [crt_pkg::DEPTH_W-1:0]   depth_out;
    logic                          is_ret_reg;
    logic [crt_pkg::FIELD_W-1:0]   pc_reg;
    logic [crt_pkg::FIELD_W-1:0]   target_reg;
    logic [crt_pkg::DEPTH_W-1:0]   depth_out_reg;

    crt_pkg::jump_t   jump;
    crt_pkg::lookup_t lookup;

    logic                  accept;
    logic                  do_clear;
    logic                  do_append;
    logic                  do_event;
    logic                  scan_busy;
    logic                  scan_done;
    logic [IDX_W-1:0]      rd_addr;
    logic [ENTRY_W-1:0]    rd_data;
    logic [ENTRY_W-1:0]    wr_data;

    crt_decode u_decode (
        .instruction (instruction),
        .jump        (jump)
    );

    // Decode the accepted transfer
    assign accept    = start && !busy;
    assign do_clear  = accept && (kind == crt_pkg::KIND_CLEAR);
    assign do_append = accept && (kind == crt_pkg::KIND_APPEND)
                       && (entry_count_reg < CNT_W'(TABLE_ENTRIES));
    assign do_event  = accept && (kind == crt_pkg::KIND_RETIRE) && trace_enable_reg
                       && (jump.is_call || jump.is_ret);

    assign wr_data = {symbol_size, ADDR_WIDTH'(symbol_start)};

    crt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (do_append),
        .waddr (entry_count_reg[IDX_W-1:0]),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    crt_scan #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_WIDTH    (ADDR_WIDTH)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (do_event),
        .target_addr  (ADDR_WIDTH'(next_address)),
        .current_addr (ADDR_WIDTH'(pc)),
        .entry_count  (entry_count_reg),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .busy         (scan_busy),
        .done         (scan_done),
        .lookup       (lookup)
    );

    // Depth shown with the event: after the return decrement, before the call increment
    always_comb
    begin
        if (jump.is_ret && (depth_reg != '0))
        begin
            depth_out = depth_reg - 1'b1;
        end
        else
        begin
            depth_out = depth_reg;
        end
    end

    // Update fill count and nesting depth
    always_comb
    begin
        entry_count_next = entry_count_reg;
        depth_next       = depth_reg;
        priority if (do_clear)
        begin
            entry_count_next = '0;
            depth_next       = '0;
        end
        else if (do_append)
        begin
            entry_count_next = entry_count_reg + 1'b1;
        end
        else if (do_event)
        begin
            if (jump.is_call)
            begin
                if (depth_reg != crt_pkg::DEPTH_MAX)
                begin
                    depth_next = depth_reg + 1'b1;
                end
            end
            else
            begin
                depth_next = depth_out;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_enable_reg <= 1'b0;
            entry_count_reg  <= '0;
            depth_reg        <= '0;
        end
        else
        begin
            if (trace_enable_we)
            begin
                trace_enable_reg <= trace_enable_wdata;
            end
            entry_count_reg <= entry_count_next;
            depth_reg       <= depth_next;
        end
    end

    // Hold the event payload while the scan runs
    always_ff @(posedge clk)
    begin
        if (do_event)
        begin
            is_ret_reg    <= !jump.is_call;
            pc_reg        <= pc;
            target_reg    <= next_address;
            depth_out_reg <= depth_out;
        end
    end

    assign busy           = scan_busy;
    assign result_valid   = scan_done;
    assign is_return      = is_ret_reg;
    assign event_pc       = pc_reg;
    assign target_address = target_reg;
    assign indent_depth   = depth_out_reg;
    assign target_found   = lookup.t_found;
    assign target_index   = lookup.t_index;
    assign current_found  = lookup.c_found;
    assign current_index  = lookup.c_index;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("table fill count exceeds capacity");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && $past(kind == crt_pkg::KIND_RETIRE))
        else $error("scan started without an accepted instruction transfer");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy) && !busy)
        else $error("result strobe not at the end of a scan");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !do_append && !do_clear)
        else $error("table changed during a scan");
`endif

endmodule
